// ===== rtl/gdft_pkg.sv =====
package gdft_pkg;

    localparam int VERTEX_W = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int EPOCH_W  = 8;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_DEGREE_DEF   = 16;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_TRAVERSE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_VISIT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic                operation;
        logic [VERTEX_W-1:0] first_vertex;
        logic [VERTEX_W-1:0] destination_vertex;
    } req_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [STATUS_W-1:0] status;
        logic                last;
    } res_t;

endpackage

// ===== rtl/gdft_ram.sv =====
module gdft_ram
    import gdft_pkg::*;
#(
    parameter int WIDTH = VERTEX_W,
    parameter int DEPTH = MAX_VERTICES_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gdft_degree.sv =====
module gdft_degree
    import gdft_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
    output logic [$clog2(MAX_DEGREE+1)-1:0]   rd_data,
    input  logic                              wr_en,
    input  logic [$clog2(MAX_VERTICES)-1:0]   wr_addr,
    input  logic [$clog2(MAX_DEGREE+1)-1:0]   wr_data
);

    localparam int GW = $clog2(MAX_DEGREE + 1);

    logic [MAX_VERTICES-1:0] valid_reg;
    logic                    rd_valid_reg;
    logic [GW-1:0]           ram_q;

    gdft_ram #(
        .WIDTH (GW),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // unwritten entries read as zero degree
    assign rd_data = rd_valid_reg ? ram_q : '0;

endmodule

// ===== rtl/graph_depth_first_traversal.sv =====
// Directed-graph store with depth-first walk. A request with operation 0 appends
// destination_vertex to the adjacency list of first_vertex and presents one result
// (stored or list full) after the S_ADD and S_EMIT states, or (out of range) after
// S_EMIT alone, when the result port is free. A request with operation 1 walks the
// graph from first_vertex with a vertex stack and answers one result per visited
// vertex in pop order, last set on the final one, or one out-of-range result. Each
// vertex passes the pop, fetch, degree, scan and flush states, each list entry the
// scan, look and check states, as the adjacency and visited memories have single
// read ports: each list entry is read, then its visited mark is read, then it is
// checked. Each vertex result is loaded once the vertex's list has been scanned, so
// last is known when it is presented. Visited marks hold a walk number; the first
// walk after reset and then one walk in every 255 first run a clearing pass over the
// visited memory. Requests are taken one at a time; req_stall is high from acceptance
// until the final result is loaded into the output register. Degree counts reset to
// zero through per-vertex valid bits. vertex_count is written through the cfg port,
// which is always ready; values above MAX_VERTICES act as MAX_VERTICES.
module graph_depth_first_traversal
    import gdft_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_t               req_data,
    output logic               res_valid,
    input  logic               res_stall,
    output res_t               res_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int GW = $clog2(MAX_DEGREE + 1);
    localparam int AW = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int DW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_ADD   = 11'b00000000010,
        S_EMIT  = 11'b00000000100,
        S_POP   = 11'b00000001000,
        S_FETCH = 11'b00000010000,
        S_DEG   = 11'b00000100000,
        S_SCAN  = 11'b00001000000,
        S_CHECK = 11'b00010000000,
        S_FLUSH = 11'b00100000000,
        S_CLEAR = 11'b01000000000,
        S_LOOK  = 11'b10000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      vertex_count_reg;
    logic [DW-1:0]           depth_reg, depth_next;
    logic [EPOCH_W-1:0]      epoch_reg, epoch_next;
    logic [IW-1:0]           clr_reg, clr_next;
    logic                    res_valid_reg, res_valid_next;
    res_t                    res_reg, res_next;
    logic [IW-1:0]           src_reg, src_next;
    logic [VERTEX_W-1:0]     dst_reg, dst_next;
    logic [VERTEX_W-1:0]     vtx_reg, vtx_next;
    logic [AW-1:0]           base_reg, base_next;
    logic [GW-1:0]           deg_reg, deg_next;
    logic [GW-1:0]           k_reg, k_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    logic [COUNT_W-1:0]      vcount;
    logic                    accept;
    logic                    slot_free;
    logic                    src_ok, dst_ok, w_ok;
    logic [DW-1:0]           depth_dec;

    logic [IW-1:0]           deg_rd_addr;
    logic [GW-1:0]           deg_q;
    logic                    deg_we;

    logic                    stk_we;
    logic [IW-1:0]           stk_wa;
    logic [VERTEX_W-1:0]     stk_wd;
    logic [VERTEX_W-1:0]     stk_q;

    logic                    adj_we;
    logic [AW-1:0]           adj_wa;
    logic [AW-1:0]           adj_ra;
    logic [VERTEX_W-1:0]     adj_q;

    logic                    vis_we;
    logic [IW-1:0]           vis_wa;
    logic [EPOCH_W-1:0]      vis_wd;
    logic [EPOCH_W-1:0]      vis_q;

    assign vcount = (vertex_count_reg > COUNT_W'(MAX_VERTICES)) ?
                    COUNT_W'(MAX_VERTICES) : vertex_count_reg;

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign slot_free = !res_valid_reg || !res_stall;
    assign cfg_ready = 1'b1;

    assign src_ok = {1'b0, req_data.first_vertex} < vcount;
    assign dst_ok = {1'b0, req_data.destination_vertex} < vcount;
    assign w_ok   = {1'b0, adj_q} < vcount;

    assign depth_dec = depth_reg - DW'(1);
    assign adj_wa    = base_reg + AW'(deg_q);
    assign adj_ra    = base_reg + AW'(k_reg);

    gdft_degree #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_degree (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (deg_rd_addr),
        .rd_data (deg_q),
        .wr_en   (deg_we),
        .wr_addr (src_reg),
        .wr_data (deg_q + GW'(1))
    );

    gdft_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (MAX_VERTICES)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_wa),
        .wr_data (stk_wd),
        .rd_addr (depth_dec[IW-1:0]),
        .rd_data (stk_q)
    );

    gdft_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (MAX_VERTICES * MAX_DEGREE)
    ) u_adjacency (
        .clk     (clk),
        .wr_en   (adj_we),
        .wr_addr (adj_wa),
        .wr_data (dst_reg),
        .rd_addr (adj_ra),
        .rd_data (adj_q)
    );

    gdft_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (MAX_VERTICES)
    ) u_visited (
        .clk     (clk),
        .wr_en   (vis_we),
        .wr_addr (vis_wa),
        .wr_data (vis_wd),
        .rd_addr (adj_q[IW-1:0]),
        .rd_data (vis_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        epoch_next     = epoch_reg;
        clr_next       = clr_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        vtx_next       = vtx_reg;
        base_next      = base_reg;
        deg_next       = deg_reg;
        k_next         = k_reg;
        status_next    = status_reg;
        deg_rd_addr    = src_reg;
        deg_we         = 1'b0;
        stk_we         = 1'b0;
        stk_wa         = depth_reg[IW-1:0];
        stk_wd         = adj_q;
        adj_we         = 1'b0;
        vis_we         = 1'b0;
        vis_wa         = adj_q[IW-1:0];
        vis_wd         = epoch_reg;

        case (state_reg)
            S_IDLE:
            begin
                deg_rd_addr = req_data.first_vertex[IW-1:0];
                if (accept)
                begin
                    src_next  = req_data.first_vertex[IW-1:0];
                    dst_next  = req_data.destination_vertex;
                    base_next = AW'(req_data.first_vertex[IW-1:0]) * AW'(MAX_DEGREE);
                    if (req_data.operation == OP_ADD_EDGE)
                    begin
                        if (src_ok && dst_ok)
                        begin
                            state_next = S_ADD;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_EMIT;
                        end
                    end
                    else if (!src_ok)
                    begin
                        status_next = ST_RANGE;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        stk_we     = 1'b1;
                        stk_wa     = '0;
                        stk_wd     = req_data.first_vertex;
                        depth_next = DW'(1);
                        if (epoch_reg == '1)
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                            vis_we     = 1'b1;
                            vis_wa     = req_data.first_vertex[IW-1:0];
                            vis_wd     = epoch_reg + EPOCH_W'(1);
                            state_next = S_POP;
                        end
                    end
                end
            end
            S_CLEAR:
            begin
                // clear every mark, mark the start vertex for walk number one
                vis_we   = 1'b1;
                vis_wa   = clr_reg;
                vis_wd   = (clr_reg == src_reg) ? EPOCH_W'(1) : '0;
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(MAX_VERTICES - 1))
                begin
                    epoch_next = EPOCH_W'(1);
                    state_next = S_POP;
                end
            end
            S_ADD:
            begin
                if (deg_q >= GW'(MAX_DEGREE))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    adj_we      = 1'b1;
                    deg_we      = 1'b1;
                    status_next = ST_STORED;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next  = 1'b1;
                    res_next.vertex = '0;
                    res_next.status = status_reg;
                    res_next.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_POP:
            begin
                depth_next = depth_dec;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                deg_rd_addr = stk_q[IW-1:0];
                vtx_next    = stk_q;
                base_next   = AW'(stk_q[IW-1:0]) * AW'(MAX_DEGREE);
                state_next  = S_DEG;
            end
            S_DEG:
            begin
                deg_next   = deg_q;
                k_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if ((k_reg == deg_reg) || (depth_reg == DW'(MAX_VERTICES)))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (w_ok && (vis_q != epoch_reg))
                begin
                    vis_we     = 1'b1;
                    stk_we     = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
                k_next     = k_reg + GW'(1);
                state_next = S_SCAN;
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    res_valid_next  = 1'b1;
                    res_next.vertex = vtx_reg;
                    res_next.status = ST_VISIT;
                    res_next.last   = (depth_reg == '0);
                    state_next      = (depth_reg == '0) ? S_IDLE : S_POP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            vertex_count_reg <= VERTEX_COUNT_RESET;
            depth_reg        <= '0;
            epoch_reg        <= '1;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            epoch_reg     <= epoch_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                vertex_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        vtx_reg    <= vtx_next;
        base_reg   <= base_next;
        deg_reg    <= deg_next;
        k_reg      <= k_next;
        status_reg <= status_next;
        clr_reg    <= clr_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(MAX_VERTICES))
        else $error("stack depth above vertex limit");

    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (k_reg <= deg_reg))
        else $error("list index past degree");

    a_degree_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (deg_reg <= GW'(MAX_DEGREE)))
        else $error("degree above list capacity");

    a_visit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status == ST_VISIT)) |-> ({1'b0, res_reg.vertex} < vcount))
        else $error("visited vertex out of range");

    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_data.operation == OP_TRAVERSE) && src_ok) |=>
            ((state_reg == S_POP) || (state_reg == S_CLEAR)) && (depth_reg == DW'(1)))
        else $error("walk did not start with one stacked vertex");

endmodule
